FILE: src/twts_pkg.sv
// Package for the two-way time sync node: transaction types, codes and sizes.
// Used by two_way_time_sync_node_core; depends on nothing else.
`default_nettype none

package twts_pkg;

  // Sizes of the timestamp and of its decimal form.
  localparam int unsigned DigitCount = 10;
  localparam int unsigned ClockWidth = 32;
  localparam int unsigned BcdWidth   = 4 * DigitCount;
  localparam int unsigned StepWidth  = $clog2(ClockWidth);
  localparam int unsigned DigWidth   = $clog2(DigitCount);

  // ASCII code of the character zero, in the width of the digit field.
  localparam logic [5:0] AsciiZero = 6'd48;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SEND  = 2'd1,
    OP_REPLY = 2'd2,
    OP_PEER  = 2'd3
  } op_e;

  // Kinds of emitted digit strings.
  typedef enum logic [1:0] {
    KIND_REQUEST   = 2'd0,
    KIND_OFFSET    = 2'd1,
    KIND_NEW_CLOCK = 2'd2,
    KIND_REPLY_TS  = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_OFF,
    ST_STEP,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_char;
  } in_item_t;

  // Output transaction: one ASCII digit.
  typedef struct packed {
    logic [1:0] message_kind;
    logic [5:0] ascii_digit;
    logic       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/two_way_time_sync_node_core.sv
// A tick or an early reply digit is handled in the idle state; a send or peer request runs the
// conversion, then the digit emission; the tenth reply digit runs the sum, offset and step
// states, then two conversion and emission runs. One transaction is in work at a time, set by the
// shared 32-step binary-to-BCD shifter and one digit per cycle while the output side takes them.
// Reset: rst_ni clears the clock, request time, reply accumulator and digit count to zero.
// Top level of the two-way time sync node; uses twts_pkg.
`default_nettype none

module two_way_time_sync_node_core
  import twts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  state_e                 state_q, state_d;
  logic [ClockWidth-1:0]  clock_q, clock_d;
  logic [ClockWidth-1:0]  req_q, req_d;
  logic [ClockWidth-1:0]  acc_q, acc_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [ClockWidth-1:0]  work_q, work_d;
  logic                   up_q, up_d;
  logic [ClockWidth-1:0]  bin_q, bin_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [StepWidth-1:0]   step_q, step_d;
  logic [DigWidth-1:0]    dig_q, dig_d;
  kind_e                  kind_q, kind_d;
  logic                   more_q, more_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   in_fire;
  logic                   out_free;
  logic [3:0]             rx_digit;
  logic [ClockWidth-1:0]  even_reply;
  logic [BcdWidth-1:0]    bcd_adj;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Characters one to nine carry their low nibble; everything else counts as zero.
  assign rx_digit = (in_data_i.rx_char >= 8'h31 && in_data_i.rx_char <= 8'h39) ?
                    in_data_i.rx_char[3:0] : 4'd0;

  // The reply value with its lowest bit cleared.
  assign even_reply = {acc_q[ClockWidth-1:1], 1'b0};

  // Add-three correction of every BCD digit ahead of the next shift.
  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 :
                          bcd_q[4*i +: 4];
    end
  end

  // Sequencer: next state and all register updates.
  always_comb begin
    state_d     = state_q;
    clock_d     = clock_q;
    req_d       = req_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    up_d        = up_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    dig_d       = dig_q;
    kind_d      = kind_q;
    more_d      = more_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bcd_d  = '0;
          step_d = '0;
          more_d = 1'b0;
          case (op_e'(in_data_i.operation))
            OP_TICK: begin
              clock_d = clock_q + 32'd1;
            end
            OP_SEND: begin
              req_d   = clock_q;
              bin_d   = clock_q;
              kind_d  = KIND_REQUEST;
              state_d = ST_CONV;
            end
            OP_REPLY: begin
              acc_d = (acc_q << 3) + (acc_q << 1) + {{(ClockWidth-4){1'b0}}, rx_digit};
              if (cnt_q == 4'(DigitCount - 1)) begin
                state_d = ST_SUM;
              end else begin
                cnt_d = cnt_q + 4'd1;
              end
            end
            OP_PEER: begin
              bin_d   = {clock_q[ClockWidth-2:0], 1'b0};
              kind_d  = KIND_REPLY_TS;
              state_d = ST_CONV;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Sum of the request time and the local clock.
      ST_SUM: begin
        work_d  = req_q + clock_q;
        state_d = ST_OFF;
      end

      // Half the absolute difference, and the direction of the step.
      ST_OFF: begin
        up_d = (even_reply > work_q);
        if (even_reply > work_q) begin
          work_d = (even_reply - work_q) >> 1;
        end else begin
          work_d = (work_q - even_reply) >> 1;
        end
        state_d = ST_STEP;
      end

      // Step the clock; the offset goes out first, the new clock after it.
      ST_STEP: begin
        clock_d = up_q ? clock_q + work_q : clock_q - work_q;
        bin_d   = work_q;
        kind_d  = KIND_OFFSET;
        more_d  = 1'b1;
        acc_d   = '0;
        cnt_d   = '0;
        bcd_d   = '0;
        step_d  = '0;
        state_d = ST_CONV;
      end

      // One double-dabble shift per cycle.
      ST_CONV: begin
        bcd_d  = {bcd_adj[BcdWidth-2:0], bin_q[ClockWidth-1]};
        bin_d  = {bin_q[ClockWidth-2:0], 1'b0};
        step_d = step_q + StepWidth'(1);
        if (step_q == StepWidth'(ClockWidth - 1)) begin
          dig_d   = '0;
          state_d = ST_EMIT;
        end
      end

      // One digit per cycle into the output register while it is free, most significant first.
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.message_kind = kind_q;
          out_d.ascii_digit  = AsciiZero + {2'b00, bcd_q[BcdWidth-1 -: 4]};
          out_d.last_of_run  = (dig_q == DigWidth'(DigitCount - 1));
          bcd_d              = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_d              = dig_q + DigWidth'(1);
          if (dig_q == DigWidth'(DigitCount - 1)) begin
            if (more_q) begin
              bin_d   = clock_q;
              kind_d  = KIND_NEW_CLOCK;
              more_d  = 1'b0;
              bcd_d   = '0;
              step_d  = '0;
              state_d = ST_CONV;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clock_q     <= '0;
      req_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      dig_q       <= '0;
      kind_q      <= KIND_REQUEST;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      req_q       <= req_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      kind_q      <= kind_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    up_q   <= up_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    out_q  <= out_d;
  end

`ifndef NO_ASSERTIONS
  // The reply digit count never reaches the string length.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(DigitCount - 1))
    else $error("reply digit count out of range");

  // A conversion always starts from an empty BCD register.
  a_conv_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && step_q == '0) |-> (bcd_q == '0))
    else $error("BCD register not cleared at conversion start");

  // A send transaction latches the clock and starts converting it.
  a_send_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.operation == OP_SEND) |=>
      (state_q == ST_CONV && req_q == $past(clock_q) && bin_q == $past(clock_q)))
    else $error("send transaction did not latch the clock");

  // A new digit is only loaded while the sequencer is emitting.
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_EMIT))
    else $error("output loaded outside the emit state");
`endif

endmodule

`default_nettype wire
